// ----- rtl/mnmt_pkg.sv -----
package mnmt_pkg;

    // Table geometry. The last slot of the table is the broadcast entry.
    localparam int TABLE_ENTRIES = 127;
    localparam int TABLE_DEPTH   = 128;
    localparam int SLOT_W        = $clog2(TABLE_DEPTH);
    localparam int ADDR_W        = 48;
    localparam int COUNT_W       = $clog2(TABLE_ENTRIES);

    localparam logic [SLOT_W-1:0] BROADCAST_SLOT = SLOT_W'(TABLE_DEPTH - 1);
    localparam logic [ADDR_W-1:0] BROADCAST_ADDR = {ADDR_W{1'b1}};

    // Request kinds.
    localparam logic REQ_RESOLVE = 1'b0;
    localparam logic REQ_READ    = 1'b1;

    typedef struct packed {
        logic              req_type;
        logic [ADDR_W-1:0] mac_address;
        logic [SLOT_W-1:0] node_slot;
    } req_t;

    typedef struct packed {
        logic              table_full;
        logic [SLOT_W-1:0] slot_index;
        logic [ADDR_W-1:0] stored_address;
    } rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_PROBE,
        ST_DONE
    } state_t;

    // Home slot of an address: low bits of the last byte, folded to 0 past the table.
    function automatic logic [SLOT_W-1:0] hash_start(input logic [ADDR_W-1:0] addr);
        logic [SLOT_W-1:0] h;
        h = addr[SLOT_W-1:0];
        return (h >= SLOT_W'(TABLE_ENTRIES)) ? '0 : h;
    endfunction

    // Next slot in the linear probe, wrapping at the end of the table.
    function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] pos);
        return (pos == SLOT_W'(TABLE_ENTRIES - 1)) ? '0 : pos + 1'b1;
    endfunction

endpackage

// ----- rtl/mnmt_ram.sv -----
module mnmt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port and one read port with registered read data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/mac_to_node_map_table.sv -----
// Read request: the slot is read when the request word is accepted, the word is registered in
// ST_READ and moved to the output register in ST_DONE. Resolve request: k slots are probed
// (1 to 127), with one table read per cycle. A new request is taken the cycle after the
// previous result moves to the output register.
// Reset is asynchronous and active low; it clears the control state and the per-slot valid
// bits, so every slot reads as zero and the broadcast slot reads as all ones right away.
module mac_to_node_map_table (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  mnmt_pkg::req_t  req,
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output mnmt_pkg::rsp_t  rsp
);

    mnmt_pkg::state_t state_reg, state_next;

    logic [mnmt_pkg::SLOT_W-1:0]      chk_pos_reg, chk_pos_next;
    logic [mnmt_pkg::COUNT_W-1:0]     count_reg, count_next;
    logic [mnmt_pkg::ADDR_W-1:0]      req_addr_reg, req_addr_next;
    mnmt_pkg::rsp_t                   res_reg, res_next;
    mnmt_pkg::rsp_t                   out_data_reg, out_data_next;
    logic                             out_valid_reg, out_valid_next;
    logic [mnmt_pkg::TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic                             rd_valid_reg, rd_valid_next;
    logic                             rd_bcast_reg, rd_bcast_next;

    logic                        ram_we;
    logic [mnmt_pkg::SLOT_W-1:0] ram_waddr;
    logic [mnmt_pkg::ADDR_W-1:0] ram_wdata;
    logic                        ram_re;
    logic [mnmt_pkg::SLOT_W-1:0] ram_raddr;
    logic [mnmt_pkg::ADDR_W-1:0] ram_rdata;

    logic                        req_fire;
    logic                        out_free;
    logic [mnmt_pkg::ADDR_W-1:0] entry;
    logic                        probe_hit;
    logic                        probe_last;
    logic [mnmt_pkg::SLOT_W-1:0] req_slot;

    // Address table storage.
    mnmt_ram #(
        .WIDTH (mnmt_pkg::ADDR_W),
        .DEPTH (mnmt_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Handshake status and response outputs.
    assign req_fire  = req_valid && req_ready;
    assign out_free  = !out_valid_reg || rsp_ready;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_data_reg;

    // A slot never written reads as zero; the broadcast slot always reads as all ones.
    always_comb
    begin
        if (rd_bcast_reg)
        begin
            entry = mnmt_pkg::BROADCAST_ADDR;
        end
        else if (rd_valid_reg)
        begin
            entry = ram_rdata;
        end
        else
        begin
            entry = '0;
        end
    end

    assign probe_hit  = (entry == req_addr_reg) || (entry == '0);
    assign probe_last = (count_reg == mnmt_pkg::COUNT_W'(mnmt_pkg::TABLE_ENTRIES - 1));
    assign req_slot   = (req.req_type == mnmt_pkg::REQ_READ) ? req.node_slot
                                                            : mnmt_pkg::hash_start(req.mac_address);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            mnmt_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    state_next = (req.req_type == mnmt_pkg::REQ_READ) ? mnmt_pkg::ST_READ
                                                                      : mnmt_pkg::ST_PROBE;
                end
            end
            mnmt_pkg::ST_READ:
            begin
                state_next = mnmt_pkg::ST_DONE;
            end
            mnmt_pkg::ST_PROBE:
            begin
                if (probe_hit || probe_last)
                begin
                    state_next = mnmt_pkg::ST_DONE;
                end
            end
            mnmt_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = mnmt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = mnmt_pkg::ST_IDLE;
            end
        endcase
    end

    // Sequencer outputs: request ready and memory port control.
    always_comb
    begin
        req_ready = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        ram_we    = 1'b0;
        ram_waddr = chk_pos_reg;
        ram_wdata = req_addr_reg;
        unique case (state_reg) inside
            mnmt_pkg::ST_IDLE:
            begin
                req_ready = 1'b1;
                ram_re    = req_valid;
                ram_raddr = req_slot;
            end
            mnmt_pkg::ST_PROBE:
            begin
                // Fetch the next slot ahead, unless this probe ends the search.
                ram_re    = !(probe_hit || probe_last);
                ram_raddr = mnmt_pkg::next_slot(chk_pos_reg);
                ram_we    = probe_hit && (entry == '0);
            end
            mnmt_pkg::ST_READ,
            mnmt_pkg::ST_DONE:
            begin
                ram_re = 1'b0;
            end
            default:
            begin
                ram_re = 1'b0;
            end
        endcase
    end

    // Datapath next values.
    always_comb
    begin
        chk_pos_next   = chk_pos_reg;
        count_next     = count_reg;
        req_addr_next  = req_addr_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        valid_next     = valid_reg;
        rd_valid_next  = rd_valid_reg;
        rd_bcast_next  = rd_bcast_reg;

        if (rsp_valid && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        // Track the valid bit of the slot being read alongside the memory read.
        if (ram_re)
        begin
            rd_valid_next = valid_reg[ram_raddr];
            rd_bcast_next = (ram_raddr == mnmt_pkg::BROADCAST_SLOT);
        end

        if (ram_we)
        begin
            valid_next[ram_waddr] = 1'b1;
        end

        case (state_reg)
            mnmt_pkg::ST_IDLE:
            begin
                if (req_fire)
                begin
                    req_addr_next = req.mac_address;
                    chk_pos_next  = req_slot;
                    count_next    = '0;
                end
            end
            mnmt_pkg::ST_READ:
            begin
                res_next.table_full     = 1'b0;
                res_next.slot_index     = chk_pos_reg;
                res_next.stored_address = entry;
            end
            mnmt_pkg::ST_PROBE:
            begin
                if (probe_hit)
                begin
                    res_next.table_full     = 1'b0;
                    res_next.slot_index     = chk_pos_reg;
                    res_next.stored_address = req_addr_reg;
                end
                else if (probe_last)
                begin
                    res_next.table_full     = 1'b1;
                    res_next.slot_index     = '0;
                    res_next.stored_address = '0;
                end
                else
                begin
                    chk_pos_next = mnmt_pkg::next_slot(chk_pos_reg);
                    count_next   = count_reg + 1'b1;
                end
            end
            mnmt_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                end
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mnmt_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
            rd_valid_reg  <= 1'b0;
            rd_bcast_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            valid_reg     <= valid_next;
            rd_valid_reg  <= rd_valid_next;
            rd_bcast_reg  <= rd_bcast_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        chk_pos_reg  <= chk_pos_next;
        count_reg    <= count_next;
        req_addr_reg <= req_addr_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

`ifndef SYNTHESIS
    // Table writes only come from a probe that found a free slot, never the broadcast slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == mnmt_pkg::ST_PROBE) && (ram_waddr != mnmt_pkg::BROADCAST_SLOT))
        else $error("table write outside a probe or to the broadcast slot");

    // The broadcast slot never gets a valid bit.
    assert property (@(posedge clk) disable iff (!rst_n)
        !valid_reg[mnmt_pkg::BROADCAST_SLOT])
        else $error("broadcast slot marked as written");

    // A written slot is marked valid on the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |=> valid_reg[$past(ram_waddr)])
        else $error("written slot not marked valid");

    // The probe never runs past one full wrap of the table.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == mnmt_pkg::ST_PROBE)
            |-> (count_reg <= mnmt_pkg::COUNT_W'(mnmt_pkg::TABLE_ENTRIES - 1)))
        else $error("probe count past table size");
`endif

endmodule
